// File: src/stale_status_watchdog_top_defines.svh
// Assertion macros shared by the stale status watchdog RTL.
`ifndef STALE_STATUS_WATCHDOG_TOP_DEFINES_SVH
`define STALE_STATUS_WATCHDOG_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stale status watchdog check failed");

// Check that cons holds in the cycle after ante.
`define SSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stale status watchdog check failed");

`endif

// File: src/ssw_pkg.sv
// Types, constants and helpers for the stale status watchdog.
`default_nettype none

package ssw_pkg;

    localparam int TIME_W         = 52;
    localparam int TIME_TOLERANCE = 1;
    localparam int TIMEOUT_W      = 32;
    localparam int CODE_W         = 6;
    localparam int REQ_W          = 8;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT = 32'd800000;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_STALE_TIMEOUT = 3'd0;

    // Alarm codes
    localparam logic [CODE_W-1:0] ALARM_NOT_READY = 6'd30;
    localparam logic [CODE_W-1:0] ALARM_BAD_INPUT = 6'd35;

    typedef enum logic [3:0] {
        CAUSE_FRESH        = 4'd0,
        CAUSE_DUPLICATE    = 4'd1,
        CAUSE_HEARTBEAT    = 4'd2,
        CAUSE_WALL_ROLL    = 4'd3,
        CAUSE_BAD_STAMP    = 4'd4,
        CAUSE_STAMP_ROLL   = 4'd5,
        CAUSE_STAMP_STALE  = 4'd6,
        CAUSE_UNKNOWN_CODE = 4'd7,
        CAUSE_NO_STATUS    = 4'd8,
        CAUSE_STATUS_STALE = 4'd9
    } cause_t;

    // Accept 14, 17, 18 and 30 through 35.
    function automatic logic code_allowed(input logic [REQ_W-1:0] c);
        return (c == 8'd14) || (c == 8'd17) || (c == 8'd18) ||
               ((c >= 8'd30) && (c <= 8'd35));
    endfunction

    // Signed elapsed time plus tolerance against the timeout.
    function automatic logic timed_out(input logic [TIME_W-1:0]    now,
                                       input logic [TIME_W-1:0]    then_t,
                                       input logic [TIMEOUT_W-1:0] timeout);
        logic [TIME_W+1:0] diff;
        diff = {2'b00, now} - {2'b00, then_t} + (TIME_W+2)'(TIME_TOLERANCE);
        return $signed(diff) >= $signed({(TIME_W+2-TIMEOUT_W)'(0), timeout});
    endfunction

endpackage

`default_nettype wire

// File: src/stale_status_watchdog_top.sv
// Stale status watchdog: input stage, decision logic, state and result register.
`default_nettype none

// Takes one item (status report or heartbeat tick) per clock and returns
// exactly one result per item, passing it through the input register and
// then the result register. The decision for an item and the update of the
// watchdog state happen together as it moves from the input register to the
// result register, so the next item sees the state it leaves. Sustained rate
// is one item per cycle; the only limit is the downstream stall, which backs
// up through the two registers.
// stale_timeout sits at byte address 0; a write of 0 loads 800000.
module stale_status_watchdog_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  mode,
    input  wire logic [ssw_pkg::REQ_W-1:0]             wanted_code,
    input  wire logic [ssw_pkg::TIME_W-1:0]            wall_now,
    input  wire logic                                  wall_time_ok,
    input  wire logic [ssw_pkg::TIME_W-1:0]            source_stamp,
    input  wire logic                                  source_stamp_ok,
    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [ssw_pkg::CODE_W-1:0]                 active_code,
    output logic                                       code_changed,
    output ssw_pkg::cause_t                            cause,
    // configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ssw_pkg::ADDR_W-1:0]            paddr,
    input  wire logic [ssw_pkg::DATA_W-1:0]            pwdata,
    output logic [ssw_pkg::DATA_W-1:0]                 prdata,
    output logic                                       pready
);

    import ssw_pkg::*;

    `include "stale_status_watchdog_top_defines.svh"

    // Input stage
    logic                  in_valid_reg;
    logic                  mode_reg;
    logic [REQ_W-1:0]      req_reg;
    logic [TIME_W-1:0]     wall_reg;
    logic                  wall_ok_reg;
    logic [TIME_W-1:0]     stamp_reg;
    logic                  stamp_ok_reg;

    // Result stage
    logic                  out_valid_reg;
    logic [CODE_W-1:0]     active_code_reg;
    logic                  code_changed_reg;
    cause_t                cause_reg;

    // Watchdog state
    logic [CODE_W-1:0]     current_alarm_reg, current_alarm_next;
    logic                  seen_status_reg, seen_status_next;
    logic                  seen_wall_reg, seen_wall_next;
    logic                  seen_stamp_reg, seen_stamp_next;
    logic [TIME_W-1:0]     receipt_time_reg, receipt_time_next;
    logic [TIME_W-1:0]     observed_wall_reg, observed_wall_next;
    logic [TIME_W-1:0]     last_stamp_reg, last_stamp_next;
    logic [TIME_W-1:0]     progress_time_reg, progress_time_next;
    logic [TIMEOUT_W-1:0]  stale_timeout_reg;

    // Handshake
    logic                  out_free;
    logic                  advance;
    logic                  load_in;
    logic                  cfg_write;

    // Decision
    logic [CODE_W-1:0]     code_n;
    cause_t                cause_n;
    logic                  wall_roll;
    logic                  stamp_bad;
    logic                  stamp_roll;
    logic                  advanced;
    logic [TIME_W-1:0]     progress_eff;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign load_in  = !in_valid_reg || advance;
    assign in_stall = !load_in;

    assign out_valid    = out_valid_reg;
    assign active_code  = active_code_reg;
    assign code_changed = code_changed_reg;
    assign cause        = cause_reg;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[ADDR_W-1] == ADDR_STALE_TIMEOUT[ADDR_W-1])
                       ? stale_timeout_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_timeout_reg <= DEFAULT_TIMEOUT;
        end
        else if (cfg_write && (paddr[ADDR_W-1] == ADDR_STALE_TIMEOUT[ADDR_W-1]))
        begin
            stale_timeout_reg <= (pwdata == '0) ? DEFAULT_TIMEOUT : pwdata;
        end
    end

    // Hold the input transfer until the result stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load_in)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in && in_valid)
        begin
            mode_reg     <= mode;
            req_reg      <= wanted_code;
            wall_reg     <= wall_now;
            wall_ok_reg  <= wall_time_ok;
            stamp_reg    <= source_stamp;
            stamp_ok_reg <= source_stamp_ok;
        end
    end

    // Decide the result and the next watchdog state
    always_comb
    begin
        current_alarm_next = current_alarm_reg;
        seen_status_next   = seen_status_reg;
        seen_wall_next     = seen_wall_reg;
        seen_stamp_next    = seen_stamp_reg;
        receipt_time_next  = receipt_time_reg;
        observed_wall_next = observed_wall_reg;
        last_stamp_next    = last_stamp_reg;
        progress_time_next = progress_time_reg;
        code_n             = current_alarm_reg;
        cause_n            = CAUSE_HEARTBEAT;

        wall_roll  = seen_wall_reg &&
                     (({1'b0, wall_reg} + (TIME_W+1)'(TIME_TOLERANCE)) <
                      {1'b0, observed_wall_reg});
        stamp_bad  = !stamp_ok_reg || (stamp_reg == '0);
        stamp_roll = seen_stamp_reg &&
                     (({1'b0, stamp_reg} + (TIME_W+1)'(TIME_TOLERANCE)) <
                      {1'b0, last_stamp_reg});
        advanced   = !seen_stamp_reg ||
                     ({1'b0, stamp_reg} >
                      ({1'b0, last_stamp_reg} + (TIME_W+1)'(TIME_TOLERANCE)));
        progress_eff = advanced ? wall_reg : progress_time_reg;

        if (!wall_ok_reg)
        begin
            code_n  = ALARM_NOT_READY;
            cause_n = CAUSE_WALL_ROLL;
        end
        else if (wall_roll)
        begin
            observed_wall_next = wall_reg;
            code_n             = ALARM_NOT_READY;
            cause_n            = CAUSE_WALL_ROLL;
        end
        else
        begin
            seen_wall_next     = 1'b1;
            observed_wall_next = wall_reg;
            if (mode_reg)
            begin
                // heartbeat tick
                if (!seen_status_reg)
                begin
                    code_n  = ALARM_NOT_READY;
                    cause_n = CAUSE_NO_STATUS;
                end
                else if (timed_out(wall_reg, receipt_time_reg, stale_timeout_reg))
                begin
                    code_n  = ALARM_NOT_READY;
                    cause_n = CAUSE_STATUS_STALE;
                end
                else if (timed_out(wall_reg, progress_time_reg, stale_timeout_reg))
                begin
                    code_n  = ALARM_NOT_READY;
                    cause_n = CAUSE_STAMP_STALE;
                end
                else
                begin
                    code_n  = current_alarm_reg;
                    cause_n = CAUSE_HEARTBEAT;
                end
            end
            else
            begin
                // status report
                seen_status_next  = 1'b1;
                receipt_time_next = wall_reg;
                if (stamp_bad)
                begin
                    code_n  = ALARM_BAD_INPUT;
                    cause_n = CAUSE_BAD_STAMP;
                end
                else if (stamp_roll)
                begin
                    last_stamp_next    = stamp_reg;
                    progress_time_next = wall_reg;
                    code_n             = ALARM_NOT_READY;
                    cause_n            = CAUSE_STAMP_ROLL;
                end
                else
                begin
                    seen_stamp_next = 1'b1;
                    if (advanced)
                    begin
                        last_stamp_next    = stamp_reg;
                        progress_time_next = wall_reg;
                    end
                    if (timed_out(wall_reg, progress_eff, stale_timeout_reg))
                    begin
                        code_n  = ALARM_NOT_READY;
                        cause_n = CAUSE_STAMP_STALE;
                    end
                    else if (!code_allowed(req_reg))
                    begin
                        code_n  = ALARM_BAD_INPUT;
                        cause_n = CAUSE_UNKNOWN_CODE;
                    end
                    else if (!advanced)
                    begin
                        code_n  = current_alarm_reg;
                        cause_n = CAUSE_DUPLICATE;
                    end
                    else
                    begin
                        code_n  = req_reg[CODE_W-1:0];
                        cause_n = CAUSE_FRESH;
                    end
                end
            end
        end
        current_alarm_next = code_n;
    end

    // Commit state as the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_alarm_reg <= ALARM_NOT_READY;
            seen_status_reg   <= 1'b0;
            seen_wall_reg     <= 1'b0;
            seen_stamp_reg    <= 1'b0;
            receipt_time_reg  <= '0;
            observed_wall_reg <= '0;
            last_stamp_reg    <= '0;
            progress_time_reg <= '0;
        end
        else if (advance)
        begin
            current_alarm_reg <= current_alarm_next;
            seen_status_reg   <= seen_status_next;
            seen_wall_reg     <= seen_wall_next;
            seen_stamp_reg    <= seen_stamp_next;
            receipt_time_reg  <= receipt_time_next;
            observed_wall_reg <= observed_wall_next;
            last_stamp_reg    <= last_stamp_next;
            progress_time_reg <= progress_time_next;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            active_code_reg  <= code_n;
            code_changed_reg <= (code_n != current_alarm_reg);
            cause_reg        <= cause_n;
        end
    end

    // Checks
    `SSW_ASSERT_NOW(a_cause_range, clk, rst_n, out_valid_reg, cause_reg <= CAUSE_STATUS_STALE)
    `SSW_ASSERT_NOW(a_wall_forces_not_ready, clk, rst_n,
                    out_valid_reg && (cause_reg == CAUSE_WALL_ROLL),
                    active_code_reg == ALARM_NOT_READY)
    `SSW_ASSERT_NOW(a_timeout_nonzero, clk, rst_n, 1'b1, stale_timeout_reg != '0)
    `SSW_ASSERT_NEXT(a_changed_matches, clk, rst_n, advance,
                     code_changed_reg == (active_code_reg != $past(current_alarm_reg)))
    `SSW_ASSERT_NEXT(a_alarm_tracks_result, clk, rst_n, advance,
                     current_alarm_reg == active_code_reg)

endmodule

`default_nettype wire

// File: sim/ssw_checker.sv
// Checker for the stale status watchdog: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module ssw_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic                           mode,
    input  wire logic [ssw_pkg::REQ_W-1:0]      wanted_code,
    input  wire logic [ssw_pkg::TIME_W-1:0]     wall_now,
    input  wire logic                           wall_time_ok,
    input  wire logic [ssw_pkg::TIME_W-1:0]     source_stamp,
    input  wire logic                           source_stamp_ok,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [ssw_pkg::CODE_W-1:0]     active_code,
    input  wire logic                           code_changed,
    input  ssw_pkg::cause_t                     cause,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ssw_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [ssw_pkg::DATA_W-1:0]     pwdata,
    input  wire logic                           pready,
    output int                                  fail_count,
    output int                                  outstanding
);
    import ssw_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Codes outside the not-ready .. bad-input range that a report may ask for
    localparam logic [REQ_W-1:0] EXTRA_CODE_A = 8'd14;
    localparam logic [REQ_W-1:0] EXTRA_CODE_B = 8'd17;
    localparam logic [REQ_W-1:0] EXTRA_CODE_C = 8'd18;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              changed;
        cause_t            cause;
    } alarm_t;

    alarm_t              pending_alarms[$];

    // Mirror of the watchdog state
    logic [CODE_W-1:0]    alarm_now;
    logic                 have_report;
    logic                 have_wall;
    logic                 have_stamp;
    logic [TIME_W-1:0]    last_receipt;
    logic [TIME_W-1:0]    last_wall;
    logic [TIME_W-1:0]    newest_stamp;
    logic [TIME_W-1:0]    last_progress;
    logic [TIMEOUT_W-1:0] timeout_reg;

    function automatic logic code_permitted(input logic [REQ_W-1:0] req);
        return req == EXTRA_CODE_A || req == EXTRA_CODE_B || req == EXTRA_CODE_C ||
               (req >= 8'(ALARM_NOT_READY) && req <= 8'(ALARM_BAD_INPUT));
    endfunction

    // Signed elapsed time with tolerance; an earlier wall time is never overdue
    function automatic logic overdue(input logic [TIME_W-1:0] now_t,
                                     input logic [TIME_W-1:0] mark);
        longint span;
        span = longint'({12'd0, now_t}) - longint'({12'd0, mark}) + TIME_TOLERANCE;
        return span >= longint'({32'd0, timeout_reg});
    endfunction

    function automatic alarm_t settle(input logic [CODE_W-1:0] code, input cause_t why);
        alarm_t res;
        res.code    = code;
        res.changed = (code != alarm_now);
        res.cause   = why;
        alarm_now   = code;
        return res;
    endfunction

    // Decide one item and advance the mirrored state
    function automatic alarm_t watchdog_decide(input logic              tick,
                                               input logic [REQ_W-1:0]  req,
                                               input logic [TIME_W-1:0] wall,
                                               input logic              wall_ok,
                                               input logic [TIME_W-1:0] stamp,
                                               input logic              stamp_ok);
        logic progressed;
        if (!wall_ok)
            return settle(ALARM_NOT_READY, CAUSE_WALL_ROLL);
        if (have_wall && (64'(wall) + TIME_TOLERANCE < 64'(last_wall))) begin
            last_wall = wall;
            return settle(ALARM_NOT_READY, CAUSE_WALL_ROLL);
        end
        have_wall = 1'b1;
        last_wall = wall;

        if (tick) begin
            if (!have_report)
                return settle(ALARM_NOT_READY, CAUSE_NO_STATUS);
            if (overdue(wall, last_receipt))
                return settle(ALARM_NOT_READY, CAUSE_STATUS_STALE);
            if (overdue(wall, last_progress))
                return settle(ALARM_NOT_READY, CAUSE_STAMP_STALE);
            return settle(alarm_now, CAUSE_HEARTBEAT);
        end

        have_report  = 1'b1;
        last_receipt = wall;
        if (!stamp_ok || stamp == '0)
            return settle(ALARM_BAD_INPUT, CAUSE_BAD_STAMP);

        if (have_stamp && (64'(stamp) + TIME_TOLERANCE < 64'(newest_stamp))) begin
            newest_stamp  = stamp;
            last_progress = wall;
            return settle(ALARM_NOT_READY, CAUSE_STAMP_ROLL);
        end

        progressed = !have_stamp || (64'(stamp) > 64'(newest_stamp) + TIME_TOLERANCE);
        if (progressed) begin
            newest_stamp  = stamp;
            last_progress = wall;
        end
        have_stamp = 1'b1;

        if (overdue(wall, last_progress))
            return settle(ALARM_NOT_READY, CAUSE_STAMP_STALE);
        if (!code_permitted(req))
            return settle(ALARM_BAD_INPUT, CAUSE_UNKNOWN_CODE);
        if (!progressed)
            return settle(alarm_now, CAUSE_DUPLICATE);
        return settle(req[CODE_W-1:0], CAUSE_FRESH);
    endfunction

    // Compare results first, then queue the prediction for a new input transfer
    always @(posedge clk or negedge rst_n) begin
        alarm_t want;
        if (!rst_n) begin
            pending_alarms.delete();
            alarm_now     = ALARM_NOT_READY;
            have_report   = 1'b0;
            have_wall     = 1'b0;
            have_stamp    = 1'b0;
            last_receipt  = '0;
            last_wall     = '0;
            newest_stamp  = '0;
            last_progress = '0;
            timeout_reg   = DEFAULT_TIMEOUT;
            fail_count    = 0;
            outstanding   = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_alarms.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result code %0d changed %0d cause %0d",
                                 $realtime, active_code, code_changed, cause);
                end else begin
                    want = pending_alarms.pop_front();
                    if (want.code !== active_code || want.changed !== code_changed ||
                        want.cause !== cause) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $write("%0t: mismatch code exp %0d got %0d", $realtime,
                                   want.code, active_code);
                            $display(", changed exp %0d got %0d, cause exp %0d got %0d",
                                     want.changed, code_changed, want.cause, cause);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
                pending_alarms.push_back(watchdog_decide(mode, wanted_code, wall_now,
                                                         wall_time_ok, source_stamp,
                                                         source_stamp_ok));

            // Track register writes
            if (psel && penable && pwrite && pready && paddr == ADDR_STALE_TIMEOUT)
                timeout_reg = (pwdata == '0) ? DEFAULT_TIMEOUT : pwdata;

            outstanding = pending_alarms.size();
        end
    end

endmodule

// File: sim/testbench.sv
// Testbench top for the stale status watchdog: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import ssw_pkg::*;

    localparam int   QUIET_LIMIT = 4000;
    localparam int   MAX_GAP     = 40;
    localparam logic MODE_REPORT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [REQ_W-1:0]  KNOWN_CODES [9] =
        '{8'd14, 8'd17, 8'd18, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35};

    typedef struct packed {
        logic              tick;
        logic [REQ_W-1:0]  req;
        logic [TIME_W-1:0] wall;
        logic              wall_ok;
        logic [TIME_W-1:0] stamp;
        logic              stamp_ok;
    } item_t;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 in_valid        = 1'b0;
    logic                 in_stall;
    logic                 mode            = 1'b0;
    logic [REQ_W-1:0]     wanted_code     = '0;
    logic [TIME_W-1:0]    wall_now        = '0;
    logic                 wall_time_ok    = 1'b0;
    logic [TIME_W-1:0]    source_stamp    = '0;
    logic                 source_stamp_ok = 1'b0;
    logic                 out_valid;
    logic                 out_stall       = 1'b0;
    logic [CODE_W-1:0]    active_code;
    logic                 code_changed;
    cause_t               cause;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [ADDR_W-1:0]    paddr           = '0;
    logic [DATA_W-1:0]    pwdata          = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int                   fail_count;
    int                   outstanding;
    int                   send_idle_pct   = 0;
    int                   stall_pct       = 0;
    int                   quiet_cycles    = 0;
    logic [TIMEOUT_W-1:0] cur_timeout     = DEFAULT_TIMEOUT;
    logic [63:0]          wall_base       = 64'd1000;
    logic [63:0]          stamp_base      = 64'd100;

    always #6 clk = ~clk;

    stale_status_watchdog_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .wanted_code     (wanted_code),
        .wall_now        (wall_now),
        .wall_time_ok    (wall_time_ok),
        .source_stamp    (source_stamp),
        .source_stamp_ok (source_stamp_ok),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .active_code     (active_code),
        .code_changed    (code_changed),
        .cause           (cause),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    ssw_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .wanted_code     (wanted_code),
        .wall_now        (wall_now),
        .wall_time_ok    (wall_time_ok),
        .source_stamp    (source_stamp),
        .source_stamp_ok (source_stamp_ok),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .active_code     (active_code),
        .code_changed    (code_changed),
        .cause           (cause),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    // Randomly stall the result channel
    always @(posedge clk)
        out_stall <= rst_n && (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Abort when nothing has moved for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("stale_status_watchdog_top verification failed");
            $finish;
        end
    end

    // Offer one item, with an optional random gap, and hold it until the transfer
    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            gap++;
            @(posedge clk);
        end
        mode            <= it.tick;
        wanted_code     <= it.req;
        wall_now        <= it.wall;
        wall_time_ok    <= it.wall_ok;
        source_stamp    <= it.stamp;
        source_stamp_ok <= it.stamp_ok;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic tick, input logic [REQ_W-1:0] req,
                               input logic [TIME_W-1:0] wall, input logic wall_ok,
                               input logic [TIME_W-1:0] stamp, input logic stamp_ok);
        item_t it;
        it = '{tick, req, wall, wall_ok, stamp, stamp_ok};
        send_item(it);
    endtask

    // Hold the sender until every queued result has come back
    task automatic wait_drained;
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_STALE_TIMEOUT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_timeout = (value == '0) ? DEFAULT_TIMEOUT : value;
    endtask

    function automatic logic [REQ_W-1:0] pick_code();
        if ($urandom_range(3) != 0)
            return KNOWN_CODES[$urandom_range(8)];
        return REQ_W'($urandom_range(255));
    endfunction

    // Mostly well-formed traffic on an advancing clock, some noise
    task automatic next_item(output item_t it);
        logic [63:0] step;
        logic [63:0] back;
        it.tick     = ($urandom_range(99) < 35);
        it.req      = pick_code();
        it.wall_ok  = 1'b1;
        it.stamp_ok = 1'b1;
        if ($urandom_range(99) < 12) begin
            it.wall     = TIME_W'({$urandom, $urandom});
            it.stamp    = ($urandom_range(3) == 0) ? '0 : TIME_W'({$urandom, $urandom});
            it.wall_ok  = 1'($urandom_range(1));
            it.stamp_ok = 1'($urandom_range(1));
            it.req      = REQ_W'($urandom_range(255));
            if ($urandom_range(7) == 0)
                it.wall = TIME_MAX;
        end else begin
            // advance the wall clock, often around the timeout boundary, or step it back slightly
            case ($urandom_range(9))
                0, 1, 2: step = 64'($urandom_range(3));
                3, 4, 5: step = 64'($urandom_range(cur_timeout / 4));
                6, 7:    begin
                    step = 64'(cur_timeout) + 64'($urandom_range(2));
                    step = step - 2;
                end
                8:       step = 64'(cur_timeout) + 64'($urandom_range(cur_timeout));
                default: begin
                    back = 64'($urandom_range(1, 3));
                    wall_base = (wall_base > back) ? wall_base - back : 64'd0;
                    step = 0;
                end
            endcase
            wall_base = wall_base + step;

            // move the source stamp: repeat, near repeat, advance or roll back
            case ($urandom_range(9))
                0, 1:    ;
                2:       stamp_base = stamp_base + 1;
                3:       if (stamp_base > 1) stamp_base = stamp_base - 1;
                4:       if (stamp_base > 60)
                             stamp_base = stamp_base - 64'($urandom_range(2, 50));
                default: stamp_base = stamp_base + 64'($urandom_range(2, 5000));
            endcase
            it.wall  = TIME_W'(wall_base);
            it.stamp = TIME_W'(stamp_base);
            if ($urandom_range(49) == 0)
                it.wall_ok = 1'b0;
            if ($urandom_range(49) == 0)
                it.stamp_ok = 1'b0;
        end
    endtask

    task automatic run_random(input int count);
        item_t it;
        repeat (count) begin
            next_item(it);
            send_item(it);
            if ($urandom_range(199) == 0)
                wait_drained();
        end
    endtask

    // Directed sequence on the default timeout of 800000
    task automatic run_directed;
        send_fields(MODE_TICK,   KNOWN_CODES[0], 52'd100,     1'b1, 52'd0,    1'b0);
        send_fields(MODE_REPORT, KNOWN_CODES[0], 52'd150,     1'b0, 52'd500,  1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[0], 52'd200,     1'b1, 52'd0,    1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[0], 52'd300,     1'b1, 52'd1000, 1'b0);
        send_fields(MODE_REPORT, KNOWN_CODES[0], 52'd400,     1'b1, 52'd1000, 1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[1], 52'd500,     1'b1, 52'd1001, 1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[2], 52'd600,     1'b1, 52'd1010, 1'b1);
        send_fields(MODE_REPORT, 8'd0,           52'd700,     1'b1, 52'd1020, 1'b1);
        send_fields(MODE_REPORT, 8'd255,         52'd800,     1'b1, 52'd1030, 1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[4],  52'd900,    1'b1, 52'd1040, 1'b1);
        // heartbeat ignores the report fields
        send_fields(MODE_TICK,   8'd255,         52'd1000,    1'b1, 52'd0,    1'b0);
        send_fields(MODE_REPORT, KNOWN_CODES[5], 52'd1100,    1'b1, 52'd1039, 1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[6], 52'd1200,    1'b1, 52'd900,  1'b1);
        // receipt exactly one timeout old
        send_fields(MODE_TICK,   KNOWN_CODES[0], 52'd801199,  1'b1, 52'd0,    1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[7], 52'd900000,  1'b1, 52'd2000, 1'b1);
        // source progress exactly one timeout old
        send_fields(MODE_REPORT, KNOWN_CODES[8], 52'd1699999, 1'b1, 52'd2000, 1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[3], 52'd1700000, 1'b1, 52'd5000, 1'b1);
        // slightly earlier wall time within tolerance
        send_fields(MODE_TICK,   KNOWN_CODES[3], 52'd1699999, 1'b1, 52'd5000, 1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[0], 52'd1000,    1'b1, 52'd5000, 1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[0], 52'd1699998, 1'b1, 52'd5000, 1'b1);
        // field extremes
        send_fields(MODE_REPORT, KNOWN_CODES[8], TIME_MAX,    1'b1, TIME_MAX, 1'b1);
        send_fields(MODE_TICK,   KNOWN_CODES[8], TIME_MAX,    1'b1, TIME_MAX, 1'b1);
        send_fields(MODE_REPORT, KNOWN_CODES[1], 52'd0,       1'b1, TIME_MAX, 1'b1);
        send_fields(MODE_TICK,   KNOWN_CODES[1], 52'd5,       1'b1, 52'd0,    1'b0);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // no idling, mid timeout
        wait_drained();
        write_timeout(32'd1000);
        run_random(340);

        // sender idle, smallest timeout
        wait_drained();
        write_timeout(32'd1);
        send_idle_pct = 60;
        run_random(340);

        // receiver stalling, zero write restores the default
        wait_drained();
        write_timeout(32'd0);
        send_idle_pct = 0;
        stall_pct     <= 60;
        run_random(340);

        // both idle lightly, largest timeout
        wait_drained();
        write_timeout(32'hFFFF_FFFF);
        send_idle_pct = 8;
        stall_pct     <= 8;
        run_random(330);

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("stale_status_watchdog_top verification clean");
        else
            $display("stale_status_watchdog_top verification failed");
        $finish;
    end

endmodule
